// ----- hdl/sads_pkg.sv -----
// Shared types and constants for the suffix automaton substring counter.
// No dependencies; used by sads_front, sads_back and the top level.
package sads_pkg;

  // default sizes
  localparam int MAX_LEN_DEF  = 1024;
  localparam int ALPHABET_DEF = 26;

  // fixed payload widths
  localparam int LETTER_W = 5;
  localparam int NEW_W    = 11;
  localparam int TOTAL_W  = 20;

  // item handed from the front end to the engine
  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                restart;
    logic                in_range;
  } item_t;

  // engine sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_NEW,
    ST_WALK,
    ST_QCHK,
    ST_CLONE,
    ST_CLOAD,
    ST_LINKQ,
    ST_FIN
  } state_t;

endpackage

// ----- hdl/suffix_automaton_distinct_substrings.sv -----
// Top level of the online suffix automaton substring counter.
// Depends on sads_pkg, sads_front and sads_back.
//
// Each accepted letter extends a suffix automaton and yields one result: the
// number of distinct substrings the letter adds and the running total for the
// prefix. A letter walks the suffix links from the last state, setting its
// transition in each state visited that has none; when that walk stops at an existing
// transition, the target is checked and, when that state must be split, it is
// cloned and transitions along the links are redirected to the clone. The
// transition memory is read one row per cycle with registered data. Ignored
// letters (capacity reached, out of range) skip the walk. After reset the
// root row is cleared before the first letter is taken. A two-entry queue
// decouples input from the engine and the output register lets the next
// letter start while a result waits.
module suffix_automaton_distinct_substrings import sads_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_restart,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [NEW_W-1:0]    out_new_count,
  output logic [TOTAL_W-1:0]  out_total_count,
  output logic                out_full_res
);

  logic  q_valid, q_ready;
  item_t q_item;

  sads_front #(.ALPHABET(ALPHABET)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_letter, .in_restart,
    .q_valid, .q_ready, .q_item
  );

  sads_back #(.MAX_LEN(MAX_LEN), .ALPHABET(ALPHABET)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_valid, .out_ready, .out_new_count, .out_total_count, .out_full_res
  );

endmodule

// ----- hdl/sads_front.sv -----
// Front end: accepts letters, classifies them and queues them for the engine.
// Depends on sads_pkg.
module sads_front import sads_pkg::*; #(
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [LETTER_W-1:0] in_letter,
  input  logic                in_restart,
  output logic                q_valid,
  input  logic                q_ready,
  output item_t               q_item
);

  // two-entry queue
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_item   = mem_r[rp_r];

  // classify and store
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r].letter   <= in_letter;
      mem_r[wp_r].restart  <= in_restart;
      mem_r[wp_r].in_range <= (32'(in_letter) < ALPHABET);
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- hdl/sads_back.sv -----
// Engine: extends the suffix automaton one letter at a time and forms results.
// Depends on sads_pkg; holds the transition, link and length memories.
module sads_back import sads_pkg::*; #(
  parameter int MAX_LEN  = MAX_LEN_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  item_t              q_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [NEW_W-1:0]   out_new_count,
  output logic [TOTAL_W-1:0] out_total_count,
  output logic               out_full_res
);

  localparam int NST = 2 * MAX_LEN;
  localparam int SW  = $clog2(NST);
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int CW  = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

  typedef logic [ALPHABET-1:0][SW-1:0] row_t;

  // memories
  row_t          trans_mem [NST];
  logic [SW-1:0] link_mem  [NST];
  logic [LW-1:0] len_mem   [NST];

  row_t          rd_row;
  logic [SW-1:0] link_rd;
  logic [LW-1:0] len_rd;

  // memory controls
  logic          tr_we, lk_we, ln_we;
  logic [SW-1:0] tr_waddr, lk_waddr, ln_waddr, rd_addr;
  row_t          tr_wdata;
  logic [SW-1:0] lk_wdata;
  logic [LW-1:0] ln_wdata;

  // sequencer and datapath registers
  state_t         state_r, state_nxt;
  logic [SW:0]    cnt_r;
  logic [SW-1:0]  last_r, cur_r, p_r, q_r, cl_r, plink_r;
  logic [LW-1:0]  plen_r, added_r, len_p_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CW-1:0]  c_r;
  logic           ok_r, full_r;
  row_t           prow_r;
  logic           outv_r;
  logic [NEW_W-1:0]   onew_r;
  logic [TOTAL_W-1:0] otot_r;
  logic           ofull_r;

  // pop-time decode
  logic          pop;
  logic [LW-1:0] eff_plen;
  logic [SW:0]   eff_cnt;
  logic [SW-1:0] eff_last;
  logic          pop_full, pop_ok;
  logic [SW-1:0] t_hit;
  logic          walk_last, len_eq, cl_match, out_free;

  assign q_ready  = (state_r == ST_IDLE);
  assign pop      = q_ready && q_valid;
  assign eff_plen = q_item.restart ? '0 : plen_r;
  assign eff_cnt  = q_item.restart ? (SW+1)'(1) : cnt_r;
  assign eff_last = q_item.restart ? '0 : last_r;
  assign pop_full = (eff_plen >= LW'(MAX_LEN));
  assign pop_ok   = !pop_full && q_item.in_range;
  assign t_hit    = rd_row[c_r];
  assign walk_last = (p_r == '0);
  assign len_eq   = (len_rd == len_p_r + LW'(1));
  assign cl_match = (prow_r[c_r] == q_r);
  assign out_free = !outv_r || out_ready;

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (tr_we) trans_mem[tr_waddr] <= tr_wdata;
    rd_row <= trans_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (lk_we) link_mem[lk_waddr] <= lk_wdata;
    link_rd <= link_mem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (ln_we) len_mem[ln_waddr] <= ln_wdata;
    len_rd <= len_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  state_nxt = ST_IDLE;
      ST_IDLE:  if (pop) state_nxt = pop_ok ? ST_NEW : ST_FIN;
      ST_NEW:   state_nxt = ST_WALK;
      ST_WALK: begin
        if (t_hit != '0) state_nxt = ST_QCHK;
        else if (walk_last) state_nxt = ST_FIN;
      end
      ST_QCHK:  state_nxt = len_eq ? ST_FIN : ST_CLONE;
      ST_CLONE: state_nxt = (cl_match && !walk_last) ? ST_CLOAD : ST_LINKQ;
      ST_CLOAD: state_nxt = ST_CLONE;
      ST_LINKQ: state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_INIT;
    endcase
  end

  // memory controls per state
  always_comb begin
    tr_we = 1'b0; tr_waddr = p_r; tr_wdata = rd_row;
    lk_we = 1'b0; lk_waddr = cur_r; lk_wdata = '0;
    ln_we = 1'b0; ln_waddr = '0; ln_wdata = '0;
    rd_addr = p_r;
    case (state_r)
      ST_INIT: begin
        tr_we = 1'b1; tr_waddr = '0; tr_wdata = '0;
        ln_we = 1'b1;
      end
      ST_IDLE: begin
        // restart empties the root row
        if (pop && q_item.restart) begin
          tr_we = 1'b1; tr_waddr = '0; tr_wdata = '0;
          ln_we = 1'b1;
        end
      end
      ST_NEW: begin
        tr_we = 1'b1; tr_waddr = cur_r; tr_wdata = '0;
        ln_we = 1'b1; ln_waddr = cur_r; ln_wdata = added_r;
      end
      ST_WALK: begin
        if (t_hit == '0) begin
          tr_we = 1'b1; tr_waddr = p_r;
          tr_wdata[c_r] = cur_r;
          if (walk_last) lk_we = 1'b1;
          else rd_addr = link_rd;
        end else begin
          rd_addr = t_hit;
        end
      end
      ST_QCHK: begin
        if (len_eq) begin
          lk_we = 1'b1; lk_wdata = q_r;
        end else begin
          // clone of q
          tr_we = 1'b1; tr_waddr = cnt_r[SW-1:0]; tr_wdata = rd_row;
          ln_we = 1'b1; ln_waddr = cnt_r[SW-1:0]; ln_wdata = len_p_r + LW'(1);
          lk_we = 1'b1; lk_waddr = cnt_r[SW-1:0]; lk_wdata = link_rd;
        end
      end
      ST_CLONE: begin
        if (cl_match) begin
          tr_we = 1'b1; tr_waddr = p_r; tr_wdata = prow_r;
          tr_wdata[c_r] = cl_r;
        end
        if (cl_match && !walk_last) rd_addr = plink_r;
        else begin
          lk_we = 1'b1; lk_wdata = cl_r;
        end
      end
      ST_LINKQ: begin
        lk_we = 1'b1; lk_waddr = q_r; lk_wdata = cl_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= (SW+1)'(1);
      last_r  <= '0;
      plen_r  <= '0;
      total_r <= '0;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // result valid: set when a result is loaded, cleared once taken
      if (state_r == ST_FIN && out_free) outv_r <= 1'b1;
      else if (out_ready) outv_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (pop) begin
            plen_r <= eff_plen;
            last_r <= eff_last;
            if (q_item.restart) total_r <= '0;
            cnt_r  <= pop_ok ? eff_cnt + (SW+1)'(1) : eff_cnt;
          end
        end
        ST_QCHK: if (!len_eq) cnt_r <= cnt_r + (SW+1)'(1);
        ST_FIN: begin
          if (out_free) begin
            if (ok_r) begin
              last_r  <= cur_r;
              plen_r  <= plen_r + LW'(1);
              total_r <= total_r + TOTAL_W'(added_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          c_r     <= CW'(q_item.letter);
          ok_r    <= pop_ok;
          full_r  <= pop_full;
          cur_r   <= eff_cnt[SW-1:0];
          p_r     <= eff_last;
          added_r <= pop_ok ? eff_plen + LW'(1) : '0;
        end
      end
      ST_WALK: begin
        if (t_hit != '0) begin
          q_r     <= t_hit;
          prow_r  <= rd_row;
          plink_r <= link_rd;
          len_p_r <= len_rd;
        end else if (!walk_last) begin
          p_r <= link_rd;
        end
      end
      ST_QCHK: begin
        added_r <= added_r - (len_p_r + LW'(1));
        cl_r    <= cnt_r[SW-1:0];
      end
      ST_CLONE: if (cl_match && !walk_last) p_r <= plink_r;
      ST_CLOAD: begin
        prow_r  <= rd_row;
        plink_r <= link_rd;
      end
      ST_FIN: begin
        if (out_free) begin
          onew_r  <= NEW_W'(added_r);
          otot_r  <= ok_r ? total_r + TOTAL_W'(added_r) : total_r;
          ofull_r <= full_r;
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = outv_r;
  assign out_new_count   = onew_r;
  assign out_total_count = otot_r;
  assign out_full_res    = ofull_r;

endmodule

// ----- hdl/sads_checker.sv -----
// Port-level checks for the suffix automaton substring counter.
// Depends on sads_pkg; bound to suffix_automaton_distinct_substrings.
module sads_port_checks import sads_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [NEW_W-1:0]   out_new_count,
  input logic [TOTAL_W-1:0] out_total_count,
  input logic               out_full_res
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_count))
    else $error("result dropped or changed while stalled");

  // an ignored full letter adds nothing
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_new_count == '0)
    else $error("full result with nonzero count");

  // no result straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result right after reset");

  // back-to-back full results keep the total
  a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_full_res ##1 out_valid && out_full_res
    |-> out_total_count == $past(out_total_count))
    else $error("total changed on ignored letter");

endmodule

bind suffix_automaton_distinct_substrings sads_port_checks u_sads_checker (
  .clk, .rst_n, .out_valid, .out_ready, .out_new_count, .out_total_count, .out_full_res
);
